// File: hdl/bqf_pkg.sv
// Shared types and constants for the biquad TDF-II filter core.
// No dependencies; used by every module under hdl/.
package bqf_pkg;

   // extra fraction bits carried in the state words beyond the sample format
   localparam int EXTRA_FRAC = 16;

   // register index port and map
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_A1 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_A2 = 3'd4;

   typedef enum logic [2:0] {
      SEL_B0,
      SEL_B1,
      SEL_B2,
      SEL_A1,
      SEL_A2
   } coef_sel_type;

   typedef enum logic {
      MUL_X,
      MUL_Y
   } mul_src_type;

   typedef enum logic [1:0] {
      ADD_ZERO,
      ADD_D1,
      ADD_D2,
      ADD_ACC
   } add_src_type;

   // per-cycle control from the sequencer to the datapath and coefficient bank
   typedef struct packed {
      logic         x_load;
      logic         mul_en;
      coef_sel_type coef_sel;
      mul_src_type  mul_src;
      logic         acc_load;
      add_src_type  add_src;
      logic         add_sub;
      logic         y_load;
      logic         scratch_load;
      logic         commit;
   } ctrl_type;

endpackage

// File: hdl/bqf_coef_bank.sv
// Coefficient register bank: five signed coefficients, written by index.
// Depends on bqf_pkg (register map, coefficient select).
module bqf_coef_bank #(
   parameter int COEF_WIDTH = 18
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [bqf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COEF_WIDTH-1:0]                csr_wdata,
   input  bqf_pkg::coef_sel_type                coef_sel,
   output logic signed [COEF_WIDTH-1:0]         coef
);

   // unity gain in Q2.(COEF_WIDTH-2)
   localparam logic signed [COEF_WIDTH-1:0] ONE = COEF_WIDTH'(1) << (COEF_WIDTH - 2);

   logic signed [COEF_WIDTH-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= ONE;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bqf_pkg::REG_B0: b0_ff <= csr_wdata;
            bqf_pkg::REG_B1: b1_ff <= csr_wdata;
            bqf_pkg::REG_B2: b2_ff <= csr_wdata;
            bqf_pkg::REG_A1: a1_ff <= csr_wdata;
            bqf_pkg::REG_A2: a2_ff <= csr_wdata;
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   always_comb begin
      unique case (coef_sel)
         bqf_pkg::SEL_B0: coef = b0_ff;
         bqf_pkg::SEL_B1: coef = b1_ff;
         bqf_pkg::SEL_B2: coef = b2_ff;
         bqf_pkg::SEL_A1: coef = a1_ff;
         bqf_pkg::SEL_A2: coef = a2_ff;
         default:         coef = b0_ff;
      endcase
   end

endmodule

// File: hdl/bqf_seq.sv
// Sequencer: walks one item through six steps on the shared multiply-add unit.
// Depends on bqf_pkg (ctrl_type and select enums). Owns rsp_valid.
module bqf_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bqf_pkg::ctrl_type ctrl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_B0,
      ST_B1,
      ST_B2,
      ST_A1,
      ST_A2,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctrl         = '0;
      ctrl.coef_sel = bqf_pkg::SEL_B0;
      ctrl.mul_src  = bqf_pkg::MUL_X;
      ctrl.add_src  = bqf_pkg::ADD_ZERO;
      state_in     = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.x_load = req_valid;
            if (req_valid) state_in = ST_B0;
         end
         ST_B0: begin
            ctrl.mul_en = 1'b1;
            state_in    = ST_B1;
         end
         ST_B1: begin
            ctrl.mul_en   = 1'b1;
            ctrl.coef_sel = bqf_pkg::SEL_B1;
            ctrl.acc_load = 1'b1;
            ctrl.add_src  = bqf_pkg::ADD_D1;
            state_in      = ST_B2;
         end
         ST_B2: begin
            ctrl.mul_en   = 1'b1;
            ctrl.coef_sel = bqf_pkg::SEL_B2;
            ctrl.acc_load = 1'b1;
            ctrl.add_src  = bqf_pkg::ADD_D2;
            ctrl.y_load   = 1'b1;
            state_in      = ST_A1;
         end
         ST_A1: begin
            ctrl.mul_en       = 1'b1;
            ctrl.coef_sel     = bqf_pkg::SEL_A1;
            ctrl.mul_src      = bqf_pkg::MUL_Y;
            ctrl.scratch_load = 1'b1;
            state_in          = ST_A2;
         end
         ST_A2: begin
            ctrl.mul_en   = 1'b1;
            ctrl.coef_sel = bqf_pkg::SEL_A2;
            ctrl.mul_src  = bqf_pkg::MUL_Y;
            ctrl.acc_load = 1'b1;
            ctrl.add_src  = bqf_pkg::ADD_ACC;
            ctrl.add_sub  = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            ctrl.add_src = bqf_pkg::ADD_D2;
            ctrl.add_sub = 1'b1;
            ctrl.commit  = out_free;
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.commit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/bqf_datapath.sv
// Datapath: one registered multiplier, one add/subtract, state words and output.
// Depends on bqf_pkg (ctrl_type, EXTRA_FRAC).
module bqf_datapath #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 18
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bqf_pkg::ctrl_type              ctrl,
   input  logic signed [COEF_WIDTH-1:0]   coef,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out
);

   localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ALIGN_W = SAMPLE_WIDTH + 19;
   localparam int STATE_W = SAMPLE_WIDTH + 20;
   localparam int ACC_W   = SAMPLE_WIDTH + 22;
   localparam int WIDE_W  = SAMPLE_WIDTH + COEF_WIDTH + 19;
   localparam int NEUTRAL = bqf_pkg::EXTRA_FRAC + 2;  // coef width giving state format as-is
   localparam int SHR     = (COEF_WIDTH > NEUTRAL) ? COEF_WIDTH - NEUTRAL : 0;
   localparam int SHL     = (COEF_WIDTH < NEUTRAL) ? NEUTRAL - COEF_WIDTH : 0;
   localparam int SHR_M1  = (SHR > 0) ? SHR - 1 : 0;

   localparam logic signed [WIDE_W-1:0] PROD_HALF =
      (SHR > 0) ? (WIDE_W'(1) << SHR_M1) : '0;
   localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'(1) << (bqf_pkg::EXTRA_FRAC - 1);
   localparam logic signed [ACC_W-1:0] Y_MAX =
      ACC_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'({1'b0, {(STATE_W-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - ACC_W'(1);

   logic signed [SAMPLE_WIDTH-1:0] x_ff, y_ff, y_in, out_ff, mul_op;
   logic signed [PROD_W-1:0]       product_ff, product_in;
   logic signed [ACC_W-1:0]        acc_ff, sum, add_a, addend, y_round;
   logic signed [STATE_W-1:0]      d1_ff, d2_ff, d1_in, d2_in;
   logic signed [WIDE_W-1:0]       prod_wide, prod_rounded;
   logic signed [ALIGN_W-1:0]      aligned;

   // shared multiplier
   assign mul_op     = (ctrl.mul_src == bqf_pkg::MUL_Y) ? y_ff : x_ff;
   assign product_in = PROD_W'(coef) * PROD_W'(mul_op);

   // bring the product to state format: round off or pad fraction bits
   assign prod_wide    = WIDE_W'(product_ff);
   assign prod_rounded = ((prod_wide + PROD_HALF) >>> SHR) <<< SHL;
   assign aligned      = prod_rounded[ALIGN_W-1:0];

   always_comb begin
      case (ctrl.add_src)
         bqf_pkg::ADD_D1:  add_a = ACC_W'(d1_ff);
         bqf_pkg::ADD_D2:  add_a = ACC_W'(d2_ff);
         bqf_pkg::ADD_ACC: add_a = acc_ff;
         default:          add_a = '0;
      endcase
   end

   assign addend = ACC_W'(aligned);
   assign sum    = ctrl.add_sub ? (add_a - addend) : (add_a + addend);

   // output sample: round half up, then clamp
   assign y_round = (acc_ff + OUT_HALF) >>> bqf_pkg::EXTRA_FRAC;
   always_comb begin
      if (y_round > Y_MAX)      y_in = Y_MAX[SAMPLE_WIDTH-1:0];
      else if (y_round < Y_MIN) y_in = Y_MIN[SAMPLE_WIDTH-1:0];
      else                      y_in = y_round[SAMPLE_WIDTH-1:0];
   end

   // new state words, clamped
   always_comb begin
      if (acc_ff > S_MAX)      d1_in = S_MAX[STATE_W-1:0];
      else if (acc_ff < S_MIN) d1_in = S_MIN[STATE_W-1:0];
      else                     d1_in = acc_ff[STATE_W-1:0];
      if (ctrl.scratch_load)   d2_in = sum[STATE_W-1:0];
      else if (sum > S_MAX)    d2_in = S_MAX[STATE_W-1:0];
      else if (sum < S_MIN)    d2_in = S_MIN[STATE_W-1:0];
      else                     d2_in = sum[STATE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.x_load)   x_ff       <= req_sample_in;
      if (ctrl.mul_en)   product_ff <= product_in;
      if (ctrl.acc_load) acc_ff     <= sum;
      if (ctrl.y_load)   y_ff       <= y_in;
      if (ctrl.commit)   out_ff     <= y_ff;
   end

   // delay_two doubles as scratch for the b2*x term until commit
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else begin
         if (ctrl.commit) d1_ff <= d1_in;
         if (ctrl.commit || ctrl.scratch_load) d2_ff <= d2_in;
      end
   end

   assign rsp_sample_out = out_ff;

endmodule

// File: hdl/biquad_tdf2_filter_core.sv
// Top level of the biquad TDF-II filter core.
// Depends on bqf_pkg, bqf_coef_bank, bqf_seq and bqf_datapath.
//
//   channel | ports                            | direction | moves
//   --------+----------------------------------+-----------+-----------------------------
//   req     | req_valid, req_stall, req_sample_in | in     | one sample item
//   rsp     | rsp_valid, rsp_stall, rsp_sample_out | out   | one filtered sample item
//   csr     | csr_write_en, csr_index, csr_wdata | in      | coefficient write, no wait
//
// Sequence: an accepted sample is captured, then the sequencer walks six steps, in
//   which the single registered multiplier forms b0*x, b1*x, b2*x, a1*y, a2*y in turn
//   while one adder folds the terms; no new sample is taken until the steps are done.
// Reset: synchronous, active high; coefficients return to b0 = 1.0, others 0,
//   and both state words clear.
// Stalls: the finished sample sits in an output register; req is taken again
//   while it waits. Only the final step waits if that register is still full.
//
// y = b0*x + d1 ; d1' = sat(b1*x - a1*y + d2) ; d2' = sat(b2*x - a2*y)
module biquad_tdf2_filter_core #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample in
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample_in,
   // sample out
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_sample_out,
   // coefficient writes
   input  logic                                csr_write_en,
   input  logic [bqf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]               csr_wdata
);

   bqf_pkg::ctrl_type            ctrl;
   logic signed [COEF_WIDTH-1:0] coef;

   // coefficient registers, read through the sequencer's select
   bqf_coef_bank #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_coef_bank (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .coef_sel     (ctrl.coef_sel),
      .coef         (coef)
   );

   // step sequencer; also owns the handshakes
   bqf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   // shared multiply-add, state and output register
   bqf_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .coef           (coef),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

// File: tb/biquad_tdf2_filter_core_tb.sv
// Self-checking bench for biquad_tdf2_filter_core: samples in, filtered samples out.
// Needs bqf_pkg and the core; carries its own bit-exact filter model and scoreboard.
// Coefficients are reprogrammed between phases, only once every output has drained.
module biquad_tdf2_filter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // default build of the core
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int STATE_W  = SAMPLE_W + 20;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic signed [COEF_W-1:0]   COEF_ONE   = COEF_W'(1) <<< (COEF_W - 2);
   localparam logic signed [COEF_W-1:0]   COEF_HALF  = COEF_W'(1) <<< (COEF_W - 3);

   // indexes past the coefficient map: writes there must be dropped
   localparam logic [bqf_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_FIRST =
      bqf_pkg::CSR_INDEX_WIDTH'(bqf_pkg::REG_A2 + 1);
   localparam logic [bqf_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_LAST  =
      {bqf_pkg::CSR_INDEX_WIDTH{1'b1}};

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 82;
   localparam int CALM_PHASE      = 4;   // no gaps and no stalls through this phase
   localparam int IDLE_PERCENT    = 17;
   localparam int TAIL_CYCLES     = 16;
   localparam int CYCLE_LIMIT     = 200000;

   typedef logic signed [SAMPLE_W-1:0] sample_word;
   typedef logic signed [COEF_W-1:0]   coef_word;
   typedef logic signed [STATE_W-1:0]  state_word;

   // ---------------------------------------------------------------------------
   // Scoreboard: runs the TDF-II recurrence on every accepted item and queues the
   // sample it should produce; outputs are compared in order.
   // ---------------------------------------------------------------------------
   class biquad_scoreboard;
      coef_word   coef [5];
      state_word  delay_one;
      state_word  delay_two;
      sample_word pending_outputs [$];
      int         mismatches;

      function new();
         coef[bqf_pkg::REG_B0] = COEF_ONE;
         coef[bqf_pkg::REG_B1] = '0;
         coef[bqf_pkg::REG_B2] = '0;
         coef[bqf_pkg::REG_A1] = '0;
         coef[bqf_pkg::REG_A2] = '0;
         delay_one    = '0;
         delay_two    = '0;
         mismatches   = 0;
      endfunction

      function void set_coef(logic [bqf_pkg::CSR_INDEX_WIDTH-1:0] idx,
                             logic [COEF_W-1:0] value);
         if (idx <= bqf_pkg::REG_A2)
            coef[idx] = signed'(value);
      endfunction

      static function longint clamp(longint v, int w);
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (w - 1)) - 1;
         lo = -hi - 1;
         if (v > hi)
            return hi;
         if (v < lo)
            return lo;
         return v;
      endfunction

      // one filter step; products already sit in the state format at these widths
      function sample_word filter_sample(sample_word x);
         longint xs;
         longint acc;
         longint ys;
         longint next_one;
         longint next_two;
         xs  = longint'(x);
         acc = longint'(coef[bqf_pkg::REG_B0]) * xs + longint'(delay_one);
         // round half up, then saturate to the sample width
         ys  = clamp((acc + (longint'(1) <<< (bqf_pkg::EXTRA_FRAC - 1)))
                     >>> bqf_pkg::EXTRA_FRAC, SAMPLE_W);
         next_one = longint'(coef[bqf_pkg::REG_B1]) * xs
                    - longint'(coef[bqf_pkg::REG_A1]) * ys
                    + longint'(delay_two);
         next_two = longint'(coef[bqf_pkg::REG_B2]) * xs
                    - longint'(coef[bqf_pkg::REG_A2]) * ys;
         delay_one = state_word'(clamp(next_one, STATE_W));
         delay_two = state_word'(clamp(next_two, STATE_W));
         return sample_word'(ys);
      endfunction

      function void note_sample(sample_word x);
         pending_outputs = {pending_outputs, filter_sample(x)};
      endfunction

      function void check_sample(sample_word got);
         sample_word want;
         if (pending_outputs.size() == 0) begin
            $error("sample_out: unexpected item, expected none, actual %0d", got);
            mismatches++;
         end else begin
            want = pending_outputs.pop_front();
            if (got !== want) begin
               $error("sample_out: expected %0d, actual %0d", want, got);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return pending_outputs.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // Block signals; those the bench drives hold known values from time zero
   // ---------------------------------------------------------------------------
   logic                                clock         = 1'b0;
   logic                                reset         = 1'b1;
   logic                                req_valid     = 1'b0;
   logic                                req_stall;
   sample_word                          req_sample_in = '0;
   logic                                rsp_valid;
   logic                                rsp_stall     = 1'b0;
   sample_word                          rsp_sample_out;
   logic                                csr_write_en  = 1'b0;
   logic [bqf_pkg::CSR_INDEX_WIDTH-1:0] csr_index     = '0;
   logic [COEF_W-1:0]                   csr_wdata     = '0;

   biquad_scoreboard sb;
   bit               calm = 1'b0;   // suppresses gaps and stalls on both sides
   int               cycle_count = 0;

   biquad_tdf2_filter_core #(
      .SAMPLE_WIDTH (SAMPLE_W),
      .COEF_WIDTH   (COEF_W)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: fails the run if it reaches CYCLE_LIMIT.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Output side: check the item taken at this edge, then pick the next stall.
   // Values read here are those seen by the core at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_sample(rsp_sample_out);
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Offer one sample, with an occasional gap first; returns on acceptance.
   task automatic send_sample(sample_word x);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do
         @(posedge clock);
      while (req_stall);
      sb.note_sample(x);
   endtask

   // Leaves the write enable high so back-to-back writes need one edge each.
   task automatic write_coef(logic [bqf_pkg::CSR_INDEX_WIDTH-1:0] idx,
                             logic [COEF_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      sb.set_coef(idx, value);
   endtask

   // Full coefficient set, plus a stray write to an unmapped index that must
   // leave everything untouched.
   task automatic program_filter(coef_word b0, coef_word b1, coef_word b2,
                                 coef_word a1, coef_word a2);
      write_coef(bqf_pkg::REG_B0, b0);
      write_coef(bqf_pkg::REG_B1, b1);
      write_coef(bqf_pkg::REG_B2, b2);
      write_coef(bqf_pkg::REG_A1, a1);
      write_coef(bqf_pkg::REG_A2, a2);
      write_coef(bqf_pkg::CSR_INDEX_WIDTH'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                 COEF_W'($urandom));
      csr_write_en <= 1'b0;
   endtask

   // Stop offering and wait until every expected output has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic coef_word extreme_coef();
      case ($urandom_range(0, 4))
         0:       return COEF_MAX;
         1:       return COEF_MIN;
         2:       return COEF_ONE;
         3:       return -COEF_ONE;
         default: return '0;
      endcase
   endfunction

   // kind 0: any bit pattern; kind 1: a stable section; kind 2: corner values
   task automatic program_random(int kind);
      int a2v;
      int span;
      case (kind)
         0: program_filter(coef_word'($urandom), coef_word'($urandom), coef_word'($urandom),
                           coef_word'($urandom), coef_word'($urandom));
         1: begin
            // |a2| <= 0.75 and |a1| < 1 + a2 keep the poles inside the unit circle
            a2v  = int'($urandom_range(0, 98304)) - 49152;
            span = 65536 + a2v - 4096;
            program_filter(coef_word'(int'($urandom_range(0, 131072)) - 65536),
                           coef_word'(int'($urandom_range(0, 131072)) - 65536),
                           coef_word'(int'($urandom_range(0, 131072)) - 65536),
                           coef_word'(int'($urandom_range(0, 2 * span)) - span),
                           coef_word'(a2v));
         end
         default: program_filter(extreme_coef(), extreme_coef(), extreme_coef(),
                                 extreme_coef(), extreme_coef());
      endcase
   endtask

   // Audio-like content: square bursts and small signals, with full-scale
   // noise and rail values mixed in.
   function automatic sample_word pick_sample(int n, int half_period, sample_word amp);
      case ($urandom_range(0, 9)) inside
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         [2:3]:   return sample_word'(int'($urandom_range(0, 1023)) - 512);
         [4:6]:   return ((n / half_period) % 2) ? amp : -amp;
         default: return sample_word'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      int         half_period;
      sample_word amp;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients make a unity-gain pass-through.
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(sample_word'(1));
      send_sample(sample_word'(-1));
      send_sample(16'sh5555);
      drain();

      // Half gain: odd inputs land exactly on the rounding tie, which goes up.
      program_filter(COEF_HALF, '0, '0, '0, '0);
      send_sample(sample_word'(1));
      send_sample(sample_word'(-1));
      send_sample(sample_word'(3));
      send_sample(sample_word'(-3));
      drain();

      // Coefficients at the rails with full-scale input: output saturates both
      // ways and the state words swing as far as they can.
      program_filter(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      drain();

      program_filter(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      drain();

      // Random phases, each with a fresh coefficient set; state carries across.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         program_random(ph % 3);
         calm        = (ph == CALM_PHASE);
         half_period = $urandom_range(1, 12);
         amp         = sample_word'($urandom);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 20 == 19) begin
               half_period = $urandom_range(1, 12);
               amp         = sample_word'($urandom);
            end
            send_sample(pick_sample(n, half_period, amp));
         end
         drain();
      end
      calm = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
